FILE: hw/rtl/fpr_pkg.sv
`default_nettype none

package fpr_pkg;

	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH    = 2'd1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;
	localparam logic [7:0]  MIN_LEN_RESET = 8'd2;

	localparam logic [7:0] SYM_STX = 8'h02;
	localparam logic [7:0] SYM_ETX = 8'h03;
	localparam logic [7:0] SYM_ENQ = 8'h05;
	localparam logic [7:0] SYM_ACK = 8'h06;
	localparam logic [7:0] SYM_NAK = 8'h15;

	localparam logic [8:0] POS_PROTO   = 9'd1;
	localparam logic [8:0] POS_LEN     = 9'd3;
	localparam logic [8:0] END_BASE    = 9'd8;
	localparam logic [8:0] END_INITIAL = 9'd6;

	localparam logic [2:0] EV_NONE      = 3'd0;
	localparam logic [2:0] EV_START     = 3'd1;
	localparam logic [2:0] EV_OK        = 3'd2;
	localparam logic [2:0] EV_TIMEOUT   = 3'd3;
	localparam logic [2:0] EV_BAD_PROTO = 3'd4;
	localparam logic [2:0] EV_BAD_LEN   = 3'd5;
	localparam logic [2:0] EV_BAD_END   = 3'd6;

	typedef struct packed {
		logic       req_type;
		logic [7:0] byte_value;
	} in_item_t;

	typedef struct packed {
		logic [2:0] event_res;
		logic       byte_valid;
		logic [8:0] byte_position;
		logic [7:0] byte_out;
		logic [7:0] data_length;
		logic       receiving;
	} out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/framed_packet_receiver_top.sv
// Frame state updates in the same cycle an item is accepted, and its result is
// registered in the output buffer. One item per cycle is taken while in_stall is low.
// A two-entry output buffer lets input continue while a result waits to be taken.
// Reset clears the frame state and the output buffer, and sets the registers
// to timeout_ticks 1000 and min_length 2.
`default_nettype none

module framed_packet_receiver_top (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            in_valid,
	output logic                           in_stall,
	input  fpr_pkg::in_item_t              in_data,
	output logic                           out_valid,
	input  wire                            out_stall,
	output fpr_pkg::out_item_t             out_data,
	input  wire                            cfg_we,
	input  wire [fpr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [fpr_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import fpr_pkg::*;

	logic      accept;
	out_item_t result;

	assign accept = in_valid && !in_stall;

	fpr_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

	fpr_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (result),
		.full      (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

FILE: hw/rtl/fpr_core.sv
`default_nettype none

module fpr_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 accept,
	input  fpr_pkg::in_item_t                   item,
	input  wire                                 cfg_we,
	input  wire [fpr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire [fpr_pkg::CFG_DATA_W-1:0]       cfg_data,
	output fpr_pkg::out_item_t                  result
);
	import fpr_pkg::*;

	logic        in_frame_q;
	logic [8:0]  position_q;
	logic [8:0]  end_pos_q;
	logic [7:0]  payload_len_q;
	logic [15:0] elapsed_q;
	logic [15:0] timeout_q;
	logic [7:0]  min_len_q;

	logic        in_frame_d;
	logic [8:0]  position_d;
	logic [8:0]  end_pos_d;
	logic [7:0]  payload_len_d;
	logic [15:0] elapsed_d;

	always_comb begin
		logic       take;
		logic       ended;
		logic [7:0] c;
		logic [7:0] plen;

		c             = item.byte_value;
		take          = 1'b0;
		ended         = 1'b0;
		plen          = c - min_len_q;
		in_frame_d    = in_frame_q;
		position_d    = position_q;
		end_pos_d     = end_pos_q;
		payload_len_d = payload_len_q;
		elapsed_d     = elapsed_q;
		result        = '0;
		result.event_res = EV_NONE;

		if (item.req_type) begin
			if (in_frame_q) begin
				if (elapsed_q != 16'hFFFF) begin
					elapsed_d = elapsed_q + 16'd1;
				end
				if (elapsed_d >= timeout_q) begin
					result.event_res = EV_TIMEOUT;
					in_frame_d       = 1'b0;
				end
			end
		end else begin
			take = in_frame_q;
			if (!in_frame_q && c == SYM_STX) begin
				in_frame_d       = 1'b1;
				take             = 1'b1;
				position_d       = '0;
				payload_len_d    = '0;
				elapsed_d        = '0;
				end_pos_d        = END_INITIAL;
				result.event_res = EV_START;
			end
			if (take) begin
				result.byte_valid    = 1'b1;
				result.byte_position = position_d;
				result.byte_out      = c;
				if (position_d == POS_PROTO && c != SYM_ENQ && c != SYM_ACK
						&& c != SYM_NAK) begin
					in_frame_d       = 1'b0;
					result.event_res = EV_BAD_PROTO;
					ended            = 1'b1;
				end
				if (!ended && position_d == POS_LEN) begin
					if (c < min_len_q) begin
						in_frame_d       = 1'b0;
						result.event_res = EV_BAD_LEN;
						ended            = 1'b1;
					end else begin
						payload_len_d = plen;
						end_pos_d     = END_BASE + {1'b0, plen};
					end
				end
				if (!ended) begin
					if (position_d >= end_pos_d) begin
						in_frame_d       = 1'b0;
						result.event_res = (c == SYM_ETX) ? EV_OK : EV_BAD_END;
					end else begin
						position_d = position_d + 9'd1;
					end
				end
			end
		end

		result.data_length = payload_len_d;
		result.receiving   = in_frame_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q    <= 1'b0;
			position_q    <= '0;
			end_pos_q     <= END_INITIAL;
			payload_len_q <= '0;
			elapsed_q     <= '0;
			timeout_q     <= TIMEOUT_RESET;
			min_len_q     <= MIN_LEN_RESET;
		end else begin
			if (accept) begin
				in_frame_q    <= in_frame_d;
				position_q    <= position_d;
				end_pos_q     <= end_pos_d;
				payload_len_q <= payload_len_d;
				elapsed_q     <= elapsed_d;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					REG_TIMEOUT_TICKS: timeout_q <= cfg_data;
					REG_MIN_LENGTH:    min_len_q <= cfg_data[7:0];
					default: ;
				endcase
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fpr_skid.sv
`default_nettype none

module fpr_skid (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 push,
	input  fpr_pkg::out_item_t  push_data,
	output logic                full,
	output logic                out_valid,
	input  wire                 out_stall,
	output fpr_pkg::out_item_t  out_data
);
	import fpr_pkg::*;

	out_item_t  head_q;
	out_item_t  tail_q;
	logic [1:0] cnt_q;
	logic       pop;

	assign full      = (cnt_q == 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_data  = head_q;
	assign pop       = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case ({push, pop})
			2'b10: begin
				if (cnt_q == 2'd0) begin
					head_q <= push_data;
				end else begin
					tail_q <= push_data;
				end
			end
			2'b01: head_q <= tail_q;
			2'b11: begin
				if (cnt_q == 2'd1) begin
					head_q <= push_data;
				end else begin
					head_q <= tail_q;
					tail_q <= push_data;
				end
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

FILE: hw/rtl/fpr_checker.sv
`default_nettype none

module fpr_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            out_valid,
	input wire                            out_stall,
	input fpr_pkg::out_item_t             out_data
);
	import fpr_pkg::*;

	// A stalled output transaction holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output payload changed while stalled");

	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == EV_START |->
			out_data.byte_valid && out_data.byte_position == 9'd0
			&& out_data.byte_out == SYM_STX && out_data.receiving)
		else $error("frame start result is inconsistent");

	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.event_res == EV_OK || out_data.event_res == EV_TIMEOUT
			|| out_data.event_res == EV_BAD_PROTO || out_data.event_res == EV_BAD_LEN
			|| out_data.event_res == EV_BAD_END) |-> !out_data.receiving)
		else $error("frame still receiving after an ending event");

	a_no_byte: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.byte_valid |->
			out_data.byte_position == 9'd0 && out_data.byte_out == 8'd0)
		else $error("byte fields set without a stored byte");

	a_timeout: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_res == EV_TIMEOUT |-> !out_data.byte_valid)
		else $error("timeout result carries a byte");

endmodule

bind framed_packet_receiver_top fpr_checker u_fpr_checker (.*);

`default_nettype wire

FILE: sim/tb_framed_packet_receiver_top.sv
`default_nettype none

module tb_framed_packet_receiver_top;
	timeunit 1ns;
	timeprecision 1ps;

	import fpr_pkg::*;

	localparam int IDLE_LIMIT = 2000;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	in_item_t link_items[$];
	out_item_t rx_reports_due[$];

	// Receiver state as the link sees it.
	logic [15:0] rx_timeout;
	logic [7:0] rx_min;
	logic rx_active;
	logic [8:0] rx_pos;
	logic [8:0] rx_end;
	logic [7:0] rx_len;
	logic [15:0] rx_ticks;

	int gap_left = 0;
	int stall_left = 0;
	int idle_cycles = 0;
	int errors = 0;
	int items_sent = 0;
	int event_seen[8];
	bit idle_on = 1'b1;
	int tick_pct = 0;
	int ph_timeout = 1000;
	int ph_min = 2;

	framed_packet_receiver_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #1 clk = ~clk;

	function automatic out_item_t rx_predict(in_item_t it);
		out_item_t r;
		logic taken;
		logic done;
		r = '0;
		r.event_res = EV_NONE;
		if (it.req_type) begin
			if (rx_active) begin
				if (rx_ticks != 16'hFFFF)
					rx_ticks = rx_ticks + 16'd1;
				if (rx_ticks >= rx_timeout) begin
					r.event_res = EV_TIMEOUT;
					rx_active = 1'b0;
				end
			end
		end else begin
			taken = rx_active;
			if (!rx_active && it.byte_value == SYM_STX) begin
				rx_active = 1'b1;
				taken = 1'b1;
				rx_pos = '0;
				rx_len = '0;
				rx_ticks = '0;
				rx_end = END_INITIAL;
				r.event_res = EV_START;
			end
			if (taken) begin
				done = 1'b0;
				r.byte_valid = 1'b1;
				r.byte_position = rx_pos;
				r.byte_out = it.byte_value;
				if (rx_pos == POS_PROTO &&
						!(it.byte_value inside {SYM_ENQ, SYM_ACK, SYM_NAK})) begin
					rx_active = 1'b0;
					r.event_res = EV_BAD_PROTO;
					done = 1'b1;
				end
				if (!done && rx_pos == POS_LEN) begin
					if (it.byte_value < rx_min) begin
						rx_active = 1'b0;
						r.event_res = EV_BAD_LEN;
						done = 1'b1;
					end else begin
						rx_len = it.byte_value - rx_min;
						rx_end = END_BASE + {1'b0, rx_len};
					end
				end
				if (!done) begin
					if (rx_pos >= rx_end) begin
						rx_active = 1'b0;
						r.event_res = (it.byte_value == SYM_ETX) ? EV_OK : EV_BAD_END;
					end else begin
						rx_pos = rx_pos + 9'd1;
					end
				end
			end
		end
		r.data_length = rx_len;
		r.receiving = rx_active;
		event_seen[r.event_res]++;
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Driver side: also tracks register writes and predicts each accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_timeout = TIMEOUT_RESET;
			rx_min = MIN_LEN_RESET;
			rx_active = 1'b0;
			rx_pos = '0;
			rx_end = END_INITIAL;
			rx_len = '0;
			rx_ticks = '0;
			in_valid <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TIMEOUT_TICKS: rx_timeout = cfg_data[15:0];
					REG_MIN_LENGTH: rx_min = cfg_data[7:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				rx_reports_due.push_back(rx_predict(in_data));
				items_sent++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (link_items.size() > 0) begin
					in_valid <= 1'b1;
					in_data <= link_items.pop_front();
					gap_left <= pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			if (idle_on && $urandom_range(99) < 20)
				stall_left <= pick_gap();
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (rx_reports_due.size() == 0) begin
				$error("result with nothing expected: event_res %0d", out_data.event_res);
				errors++;
			end else begin
				want = rx_reports_due.pop_front();
				check_field("event_res", want.event_res, out_data.event_res);
				check_field("byte_valid", want.byte_valid, out_data.byte_valid);
				check_field("byte_position", want.byte_position, out_data.byte_position);
				check_field("byte_out", want.byte_out, out_data.byte_out);
				check_field("data_length", want.data_length, out_data.data_length);
				check_field("receiving", want.receiving, out_data.receiving);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_tick();
		link_items.push_back('{req_type: 1'b1, byte_value: 8'($urandom)});
	endtask

	task automatic push_byte(input logic [7:0] b);
		if (tick_pct != 0 && $urandom_range(99) < tick_pct)
			push_tick();
		link_items.push_back('{req_type: 1'b0, byte_value: b});
	endtask

	task automatic push_frame(input logic [7:0] proto, input logic [7:0] len_byte,
			input int body, input logic [7:0] tail);
		push_byte(SYM_STX);
		push_byte(proto);
		push_byte(8'($urandom));
		push_byte(len_byte);
		for (int i = 0; i < body; i++)
			push_byte(8'($urandom));
		push_byte(tail);
	endtask

	task automatic push_random_burst();
		int pick;
		int pay;
		int n;
		logic [7:0] proto;
		pick = $urandom_range(99);
		if ($urandom_range(19) == 0)
			pay = $urandom_range(1) ? 255 : $urandom_range(255);
		else
			pay = $urandom_range(12);
		if (pay > 255 - ph_min)
			pay = 255 - ph_min;
		case ($urandom_range(2))
			0: proto = SYM_ENQ;
			1: proto = SYM_ACK;
			default: proto = SYM_NAK;
		endcase
		if (pick < 65) begin
			push_frame(proto, 8'(ph_min + pay), 4 + pay, SYM_ETX);
		end else if (pick < 73) begin
			push_frame(8'($urandom), 8'(ph_min + pay), 4 + pay, SYM_ETX);
		end else if (pick < 80 && ph_min > 0) begin
			push_frame(proto, 8'($urandom_range(ph_min - 1)), 4 + pay, SYM_ETX);
		end else if (pick < 88) begin
			push_frame(proto, 8'(ph_min + pay), 4 + pay, 8'($urandom));
		end else if (pick < 94) begin
			push_byte(SYM_STX);
			push_byte(proto);
			push_byte(8'($urandom));
			push_byte(8'(ph_min + pay));
			repeat ($urandom_range(0, 3))
				push_byte(8'($urandom));
			n = (ph_timeout <= 40) ? ph_timeout : $urandom_range(1, 5);
			repeat (n)
				push_tick();
		end else begin
			repeat ($urandom_range(1, 6)) begin
				if ($urandom_range(1))
					push_tick();
				else
					push_byte(8'($urandom));
			end
		end
	endtask

	task automatic wait_drained();
		while (link_items.size() != 0 || in_valid || rx_reports_due.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_phase(input int timeout, input int min_len, input int count);
		wait_drained();
		ph_timeout = timeout;
		ph_min = min_len;
		write_reg(REG_TIMEOUT_TICKS, timeout);
		write_reg(REG_MIN_LENGTH, min_len);
		while (link_items.size() < count)
			push_random_burst();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: idle tick and byte, a clean frame with STX as data,
		// then one frame each for a bad protocol, a bad length and a bad end.
		push_tick();
		push_byte(8'hFF);
		push_byte(SYM_STX);
		push_byte(SYM_ENQ);
		push_byte(8'h00);
		push_byte(8'd2);
		push_byte(SYM_STX);
		push_byte(8'h80);
		push_byte(8'h7F);
		push_byte(8'hFF);
		push_byte(SYM_ETX);
		push_byte(SYM_STX);
		push_byte(8'h00);
		push_byte(SYM_STX);
		push_byte(SYM_ACK);
		push_byte(8'h55);
		push_byte(8'd1);
		push_byte(SYM_STX);
		push_byte(SYM_NAK);
		push_byte(8'hAA);
		push_byte(8'd2);
		repeat (4) push_byte(8'h00);
		push_byte(8'hFF);

		tick_pct = 2;
		while (link_items.size() < 150)
			push_random_burst();

		tick_pct = 3;
		run_phase(1, 0, 200);
		tick_pct = 5;
		run_phase(65535, 255, 200);
		wait_drained();
		write_reg(REG_SPARE_A, $urandom);
		write_reg(REG_SPARE_B, $urandom);
		run_phase($urandom_range(2, 30), $urandom_range(0, 20), 200);
		idle_on = 1'b0;
		tick_pct = 1;
		run_phase(1000, 2, 250);
		wait_drained();

		$display("Run covered %0d link transactions over five register settings.", items_sent);
		$display("Frames: %0d ok, %0d timed out, %0d bad protocol, %0d bad length, %0d bad end.",
			event_seen[EV_OK], event_seen[EV_TIMEOUT], event_seen[EV_BAD_PROTO],
			event_seen[EV_BAD_LEN], event_seen[EV_BAD_END]);
		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

`default_nettype wire
